/* rtl/blcu_pkg.sv */
// blcu_pkg: shared types and constants of the bounded list unit
// request/response payloads, mode and state codes, controller/datapath bundles
// no dependencies
package blcu_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned KEY_W     = 6;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic             REG_CAP_LIMIT = 1'b0;
    localparam logic [CNT_W-1:0] CAP_RESET     = 7'd64;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [3:0] key_rank;
        logic [1:0] key_suit;
    } t_req;

    typedef struct packed {
        logic             status_error;
        logic             found;
        logic [CNT_W-1:0] count_after;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_CLEAR,
        ST_SCAN,
        ST_SHIFT,
        ST_POST
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan;
        logic shift_start;
        logic shift;
        logic append;
        logic clear;
        logic dec;
        logic post;
        logic err;
        logic fnd;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic hit;
        logic walk_end;
        logic out_busy;
    } t_dp_st;

endpackage

/* rtl/blcu_ctrl.sv */
// blcu_ctrl: request sequencer of the bounded list unit
// drives datapath commands from the request mode and datapath status
// depends on blcu_pkg
module blcu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  blcu_pkg::t_mode  i_mode,
    input  blcu_pkg::t_dp_st i_st,
    output logic             o_req_ready,
    output blcu_pkg::t_dp_cmd o_cmd
);
    import blcu_pkg::*;

    t_state r_state, n_state;
    logic   r_remove, n_remove;
    logic   r_err, n_err;
    logic   r_fnd, n_fnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_remove <= 1'b0;
            r_err    <= 1'b0;
            r_fnd    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_remove <= n_remove;
            r_err    <= n_err;
            r_fnd    <= n_fnd;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_remove    = r_remove;
        n_err       = r_err;
        n_fnd       = r_fnd;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_err      = 1'b0;
                    n_fnd      = 1'b0;
                    n_remove   = (i_mode == MODE_REMOVE);
                    unique case (i_mode) inside
                        MODE_APPEND: n_state = ST_APPEND;
                        MODE_REMOVE, MODE_QUERY: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                        default: n_state = ST_CLEAR;
                    endcase
                end
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_err        = i_st.full;
                n_state      = ST_POST;
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_POST;
            end
            ST_SCAN: begin
                if (i_st.hit) begin
                    if (r_remove) begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = ST_SHIFT;
                    end else begin
                        n_fnd   = 1'b1;
                        n_state = ST_POST;
                    end
                end else if (i_st.walk_end) begin
                    n_err   = r_remove;
                    n_state = ST_POST;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (i_st.walk_end) begin
                    o_cmd.dec = 1'b1;
                    n_state   = ST_POST;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            ST_POST: begin
                if (!i_st.out_busy) begin
                    o_cmd.post = 1'b1;
                    o_cmd.err  = r_err;
                    o_cmd.fnd  = r_fnd;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* rtl/blcu_dp.sv */
// blcu_dp: datapath of the bounded list unit
// entry memory, count, walk pointer and response register
// depends on blcu_pkg
module blcu_dp #(
    parameter int unsigned DEPTH = blcu_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  blcu_pkg::t_req             i_req,
    input  logic [blcu_pkg::CNT_W-1:0] i_cap,
    input  blcu_pkg::t_dp_cmd          i_cmd,
    input  logic                       i_rsp_ready,
    output blcu_pkg::t_dp_st           o_st,
    output blcu_pkg::t_rsp             o_rsp,
    output logic                       o_rsp_valid
);
    import blcu_pkg::*;

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned DCAP = (DEPTH < 127) ? DEPTH : 127;
    localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'(DCAP);

    logic [KEY_W-1:0] r_mem [DEPTH];

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_rdata;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pend_idx;
    logic             r_pend, n_pend;
    t_rsp             r_rsp;
    logic             r_rsp_valid;

    logic             full;
    logic             walk_more;
    logic             rd_en;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    assign full      = (r_count >= i_cap) || (r_count >= DEPTH_CAP);
    assign walk_more = (r_idx < r_count);
    assign rd_en     = (i_cmd.scan || i_cmd.shift) && walk_more;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(r_count);
        wr_data = r_key;
        if (i_cmd.append && !full) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift && r_pend) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_pend_idx - 7'd1);
            wr_data = r_rdata;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.append && !full) begin
            n_count = r_count + 7'd1;
        end else if (i_cmd.dec) begin
            n_count = r_count - 7'd1;
        end
    end

    always_comb begin
        n_idx  = r_idx;
        n_pend = r_pend;
        if (i_cmd.scan_start) begin
            n_idx  = '0;
            n_pend = 1'b0;
        end else if (i_cmd.shift_start) begin
            n_idx  = r_pend_idx + 7'd1;
            n_pend = 1'b0;
        end else if (i_cmd.scan || i_cmd.shift) begin
            n_pend = rd_en;
            if (rd_en) begin
                n_idx = r_idx + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (i_cmd.post) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= {i_req.key_rank, i_req.key_suit};
        end
        if (rd_en) begin
            r_pend_idx <= r_idx;
        end
        if (i_cmd.post) begin
            r_rsp.status_error <= i_cmd.err;
            r_rsp.found        <= i_cmd.fnd;
            r_rsp.count_after  <= r_count;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[AW'(r_idx)];
        end
    end

    assign o_st.full     = full;
    assign o_st.hit      = r_pend && (r_rdata == r_key);
    assign o_st.walk_end = !r_pend && !walk_more;
    assign o_st.out_busy = r_rsp_valid && !i_rsp_ready;
    assign o_rsp         = r_rsp;
    assign o_rsp_valid   = r_rsp_valid;

endmodule

/* rtl/bounded_list_with_compaction_unit.sv */
// bounded_list_with_compaction_unit: top level of the bounded list unit
// holds the capacity register and joins blcu_ctrl and blcu_dp
// depends on blcu_pkg, blcu_ctrl, blcu_dp
//
// Ordered list of up to min(capacity_limit, DEPTH) six-bit rank/suit keys in
// an entry memory with one write port and one registered read port. A request
// is taken only when the sequencer is idle; its response goes to an output
// register, so the next request can be taken while a response still waits.
// Append and clear pass through their own state and then the post state,
// which loads the response register. Query walks the list one entry per
// cycle through the read port. Remove walks to the first match and then
// moves each later entry down one place, reading the next entry while it
// writes the previous one. The sequencer is idle again in the same cycle
// as the response is raised; raising a response waits while an earlier
// one has not been taken. capacity_limit is at byte address 0 of the APB
// port and resets to 64.
module bounded_list_with_compaction_unit #(
    parameter int unsigned DEPTH = blcu_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blcu_pkg::t_req              i_req,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    output blcu_pkg::t_rsp              o_rsp,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [blcu_pkg::APB_AW-1:0] paddr,
    input  logic [blcu_pkg::APB_DW-1:0] pwdata,
    output logic [blcu_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import blcu_pkg::*;

    logic [CNT_W-1:0] r_cap;
    t_dp_cmd          cmd;
    t_dp_st           st;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_CAP_LIMIT)) begin
            r_cap <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAP_LIMIT) begin
            prdata = {{(APB_DW-CNT_W){1'b0}}, r_cap};
        end
    end

    blcu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_mode      (i_req.mode),
        .i_st        (st),
        .o_req_ready (o_req_ready),
        .o_cmd       (cmd)
    );

    blcu_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cap       (r_cap),
        .i_cmd       (cmd),
        .i_rsp_ready (i_rsp_ready),
        .o_st        (st),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_rsp_valid)
    );

endmodule

/* rtl/blcu_checker.sv */
// blcu_checker: port-level assertions for the bounded list unit
// bound to bounded_list_with_compaction_unit; depends on blcu_pkg
module blcu_checker #(
    parameter int unsigned DEPTH = blcu_pkg::DEPTH_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        o_req_ready,
    input blcu_pkg::t_rsp              o_rsp,
    input logic                        o_rsp_valid,
    input logic                        i_rsp_ready
);
    import blcu_pkg::*;

    localparam int unsigned DCAP = (DEPTH < 127) ? DEPTH : 127;
    localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'(DCAP);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid)
        else $error("response dropped before it was taken");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one still in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.count_after <= DEPTH_CAP))
        else $error("count beyond list depth");

    a_err_fnd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.status_error && o_rsp.found))
        else $error("error and found both set");

endmodule

bind bounded_list_with_compaction_unit blcu_checker #(
    .DEPTH (DEPTH)
) u_blcu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp       (o_rsp),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for bounded_list_with_compaction_unit
// queue-fed request driver with its own list predictor, response monitor, apb setup
// depends on blcu_pkg and the rtl of the unit
module tb_top;
    import blcu_pkg::*;

    localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
    localparam int unsigned STUCK_LIMIT = 5000;
    localparam int unsigned DRAIN_WAIT  = 150;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 180;
    localparam logic [APB_AW-1:0] CAP_ADDR = APB_AW'(4 * int'(REG_CAP_LIMIT));

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    t_req              i_req       = '0;
    logic              i_req_valid = 1'b0;
    logic              o_req_ready;
    t_rsp              o_rsp;
    logic              o_rsp_valid;
    logic              i_rsp_ready = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // list shadow and capacity shadow
    logic [KEY_W-1:0]  list_keys [LIST_DEPTH];
    int unsigned       list_len  = 0;
    logic [CNT_W-1:0]  cap_limit = CAP_RESET;

    t_req              req_pending  [$];
    t_rsp              rsp_expected [$];

    bit                quiet        = 1'b0;
    int unsigned       drv_gap      = 0;
    int unsigned       mon_wait     = 0;
    int unsigned       hold_left    = 0;
    int unsigned       stuck_cycles = 0;
    int unsigned       err_count    = 0;
    int unsigned       rsp_seen     = 0;
    int unsigned       err_rsps     = 0;
    int unsigned       query_hits   = 0;
    int unsigned       peak_count   = 0;
    int unsigned       mode_seen [4] = '{0, 0, 0, 0};
    int unsigned       phase_caps [6] = '{64, 5, 1, 127, 40, 64};

    bounded_list_with_compaction_unit #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .o_rsp      (o_rsp),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned gap_draw();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic t_rsp list_apply(t_req r);
        t_rsp             res;
        logic [KEY_W-1:0] key;
        int unsigned      lim;
        int unsigned      pos;
        int unsigned      i;
        res = '0;
        key = {r.key_rank, r.key_suit};
        lim = (cap_limit < LIST_DEPTH) ? cap_limit : LIST_DEPTH;
        pos = list_len;
        for (i = 0; i < list_len; i++) begin
            if (list_keys[i] == key) begin
                pos = i;
                break;
            end
        end
        case (r.mode)
            MODE_APPEND: begin
                if (list_len >= lim) begin
                    res.status_error = 1'b1;
                end else begin
                    list_keys[list_len] = key;
                    list_len++;
                end
            end
            MODE_REMOVE: begin
                if (pos >= list_len) begin
                    res.status_error = 1'b1;
                end else begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_keys[i] = list_keys[i + 1];
                    list_len--;
                end
            end
            MODE_QUERY: begin
                res.found = (pos < list_len);
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.count_after = CNT_W'(list_len);
        return res;
    endfunction

    function automatic t_req req_of(t_mode m, logic [3:0] rank, logic [1:0] suit);
        t_req r;
        r.mode     = m;
        r.key_rank = rank;
        r.key_suit = suit;
        return r;
    endfunction

    // small key pool so removes and queries hit often
    function automatic t_req req_random();
        int unsigned pick;
        t_mode       m;
        logic [3:0]  rank;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            m = MODE_APPEND;
        else if (pick < 75)
            m = MODE_REMOVE;
        else if (pick < 97)
            m = MODE_QUERY;
        else
            m = MODE_CLEAR;
        if ($urandom_range(0, 4) == 0)
            rank = 4'($urandom_range(0, 15));
        else
            rank = 4'($urandom_range(0, 1));
        return req_of(m, rank, 2'($urandom_range(0, 3)));
    endfunction

    function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function automatic void rsp_check(t_rsp got);
        t_rsp want;
        rsp_seen++;
        if (got.status_error)
            err_rsps++;
        if (got.found)
            query_hits++;
        if (got.count_after > peak_count)
            peak_count = got.count_after;
        if (rsp_expected.size() == 0) begin
            flag_mismatch("response with none pending, count_after", 0, got.count_after);
        end else begin
            want = rsp_expected.pop_front();
            if (got.status_error !== want.status_error)
                flag_mismatch("status_error", want.status_error, got.status_error);
            if (got.found !== want.found)
                flag_mismatch("found", want.found, got.found);
            if (got.count_after !== want.count_after)
                flag_mismatch("count_after", want.count_after, got.count_after);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            drv_gap = gap_draw();
        end else begin
            if (i_req_valid && o_req_ready) begin
                rsp_expected.push_back(list_apply(i_req));
                mode_seen[i_req.mode]++;
            end
            if (!i_req_valid || o_req_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_req_valid <= 1'b0;
                end else if (req_pending.size() > 0) begin
                    i_req       <= req_pending.pop_front();
                    i_req_valid <= 1'b1;
                    drv_gap = gap_draw();
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor, with long hold-offs to back up the unit
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            mon_wait  = 0;
            hold_left = 0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                rsp_check(o_rsp);
                mon_wait = gap_draw();
                if (rsp_seen == 200 || rsp_seen == 750)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_ready <= 1'b0;
            end else if (mon_wait > 0) begin
                mon_wait--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) || psel)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stuck_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic list_drain();
        while (req_pending.size() > 0 || i_req_valid || rsp_expected.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cap_set(logic [CNT_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cap_limit = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CNT_W-1:0] !== val)
            flag_mismatch("capacity_limit read back", val, prdata[CNT_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_req        fill_first;
        t_req        fill_last;
        int unsigned ph;
        int unsigned n;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, duplicates, first-match remove, clear keeps stale keys hidden
        req_pending.push_back(req_of(MODE_QUERY,  4'd0,  2'd0));
        req_pending.push_back(req_of(MODE_REMOVE, 4'd0,  2'd0));
        req_pending.push_back(req_of(MODE_APPEND, 4'd15, 2'd3));
        req_pending.push_back(req_of(MODE_APPEND, 4'd0,  2'd0));
        req_pending.push_back(req_of(MODE_APPEND, 4'd15, 2'd3));
        req_pending.push_back(req_of(MODE_APPEND, 4'd5,  2'd2));
        req_pending.push_back(req_of(MODE_QUERY,  4'd15, 2'd3));
        req_pending.push_back(req_of(MODE_QUERY,  4'd0,  2'd1));
        req_pending.push_back(req_of(MODE_REMOVE, 4'd15, 2'd3));
        req_pending.push_back(req_of(MODE_QUERY,  4'd15, 2'd3));
        req_pending.push_back(req_of(MODE_REMOVE, 4'd10, 2'd1));
        req_pending.push_back(req_of(MODE_CLEAR,  4'd0,  2'd0));
        req_pending.push_back(req_of(MODE_QUERY,  4'd5,  2'd2));
        req_pending.push_back(req_of(MODE_REMOVE, 4'd5,  2'd2));
        list_drain();

        // zero capacity
        cap_set(7'd0);
        req_pending.push_back(req_of(MODE_APPEND, 4'd9,  2'd1));
        req_pending.push_back(req_of(MODE_APPEND, 4'd6,  2'd2));
        req_pending.push_back(req_of(MODE_QUERY,  4'd9,  2'd1));
        req_pending.push_back(req_of(MODE_CLEAR,  4'd3,  2'd3));
        list_drain();

        // capacity above depth, fill past the end
        cap_set(7'd127);
        for (n = 0; n < LIST_DEPTH + 2; n++) begin
            fill_last      = req_random();
            fill_last.mode = MODE_APPEND;
            if (n == 0)
                fill_first = fill_last;
            if (n < LIST_DEPTH)
                req_pending.push_back(fill_last);
            else
                req_pending.push_back(req_of(MODE_APPEND, fill_last.key_rank, 2'd0));
        end
        list_drain();

        // capacity lowered below the current count
        cap_set(7'd3);
        req_pending.push_back(req_of(MODE_APPEND, 4'd2, 2'd2));
        req_pending.push_back(req_of(MODE_REMOVE, fill_first.key_rank, fill_first.key_suit));
        req_pending.push_back(req_of(MODE_REMOVE, fill_last.key_rank, fill_last.key_suit));
        req_pending.push_back(req_of(MODE_QUERY,  fill_last.key_rank, fill_last.key_suit));
        req_pending.push_back(req_of(MODE_APPEND, 4'd2, 2'd2));
        req_pending.push_back(req_of(MODE_CLEAR,  4'd0, 2'd0));
        for (n = 0; n < 4; n++)
            req_pending.push_back(req_of(MODE_APPEND, 4'(n), 2'(n)));
        list_drain();

        for (ph = 0; ph < 6; ph++) begin
            cap_set(CNT_W'(phase_caps[ph]));
            quiet = (ph % 3 == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                req_pending.push_back(req_random());
            list_drain();
        end

        $display("ran %0d requests: %0d append, %0d remove, %0d query, %0d clear",
                 rsp_seen, mode_seen[MODE_APPEND], mode_seen[MODE_REMOVE],
                 mode_seen[MODE_QUERY], mode_seen[MODE_CLEAR]);
        $display("%0d error responses, %0d query hits, list peaked at %0d entries",
                 err_rsps, query_hits, peak_count);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/blcu_pkg.sv
rtl/blcu_ctrl.sv
rtl/blcu_dp.sv
rtl/bounded_list_with_compaction_unit.sv
rtl/blcu_checker.sv
verif/tb_top.sv
